/* src/pmt_pkg.sv */
// Shared types and constants for the multi-channel PWM timer.
// Used by every module of the block except pmt_fifo; no dependencies of its own.
package pmt_pkg;

  // Defaults for top-level parameters
  localparam int CHANNELS_DEF     = 3;
  localparam int COUNTER_BITS_DEF = 16;
  localparam int QUEUE_DEPTH      = 2;

  // Field widths
  localparam int LEVEL_W = 16;
  localparam int PIN_W   = 3;
  localparam int PSC_W   = 15;

  // Input opcodes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_SET     = 2'd1;
  localparam logic [1:0] OP_ALL_OFF = 2'd2;
  localparam logic [1:0] OP_ALL_ON  = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_PRESCALE_SHIFT = 3'd0;
  localparam logic [2:0] REG_PERIOD         = 3'd1;
  localparam logic [2:0] REG_COUNTER_ENABLE = 3'd2;
  localparam logic [2:0] REG_POLARITY       = 3'd3;
  localparam logic [2:0] REG_OUTPUT_MASK    = 3'd4;

  // Configuration reset values
  localparam logic [3:0]  RST_SHIFT    = 4'd4;
  localparam logic [15:0] RST_PERIOD   = 16'd10000;
  localparam logic        RST_ENABLE   = 1'b1;
  localparam logic        RST_POLARITY = 1'b0;
  localparam logic [2:0]  RST_OUTMASK  = 3'd7;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         channel;
    logic [LEVEL_W-1:0] level;
  } item_t;

  typedef struct packed {
    logic [PIN_W-1:0]   pwm_out;
    logic               update_event;
    logic [LEVEL_W-1:0] counter_value;
  } result_t;

  typedef struct packed {
    logic [3:0]         prescale_shift;
    logic [LEVEL_W-1:0] period;
    logic               counter_enable;
    logic               output_polarity;
    logic [PIN_W-1:0]   output_enable_mask;
  } cfg_t;

  // Classified command handed from front to back
  typedef enum logic [2:0] {
    CMD_NOP     = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_SET     = 3'd2,
    CMD_ALL_OFF = 3'd3,
    CMD_ALL_ON  = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [1:0]         channel;
    logic [LEVEL_W-1:0] level;
  } cmd_t;

endpackage

/* src/multi_channel_pwm_timer.sv */
// Top level of the multi-channel PWM timer: config registers, front, queues, back.
// Depends on pmt_pkg, pmt_fifo, pmt_front and pmt_back.
//
// Usage:
//   Input side is a queue: drive item and push; the transaction is taken at a
//   clock edge with push high and full low. Ops are tick, set level, all off
//   and all on. Every item gives exactly one result.
//   Result side is a queue: while empty is low the oldest result sits on
//   result; it is taken at a clock edge with pop high.
//   Configuration: cfg_wr_en, cfg_index and cfg_data write one register per
//   cycle with no wait; write only while the block is idle.
//   Path: a taken item waits as a command in the command queue until the back
//   end runs it; its result is written to the result queue, shows on result
//   and can then be popped.
//   Throughput: one item per cycle while the result queue has room; the back end
//   executes one command a cycle through a combinational counter and compare path.
//   Stall: when pop stays low the result queue fills, the back end stops, the
//   command queue fills and full rises; nothing is dropped.
//   Reset (rst, synchronous): queues empty, counters and all levels zero,
//   config registers back to their defaults (shift 4, period 10000, enabled,
//   active high, all outputs enabled).
module multi_channel_pwm_timer #(
  parameter int CHANNELS     = pmt_pkg::CHANNELS_DEF,
  parameter int COUNTER_BITS = pmt_pkg::COUNTER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pmt_pkg::item_t    item,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output pmt_pkg::result_t  result,
  input  logic              cfg_wr_en,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import pmt_pkg::*;

  cfg_t    cfg;
  cmd_t    front_cmd;
  cmd_t    back_cmd;
  result_t back_result;
  logic    cmd_push;
  logic    cmd_pop;
  logic    cmd_empty;
  logic    res_push;
  logic    out_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prescale_shift     <= RST_SHIFT;
      cfg.period             <= RST_PERIOD;
      cfg.counter_enable     <= RST_ENABLE;
      cfg.output_polarity    <= RST_POLARITY;
      cfg.output_enable_mask <= RST_OUTMASK;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PRESCALE_SHIFT: cfg.prescale_shift     <= cfg_data[3:0];
        REG_PERIOD:         cfg.period             <= cfg_data;
        REG_COUNTER_ENABLE: cfg.counter_enable     <= cfg_data[0];
        REG_POLARITY:       cfg.output_polarity    <= cfg_data[0];
        REG_OUTPUT_MASK:    cfg.output_enable_mask <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Classify incoming transactions
  pmt_front #(.CHANNELS(CHANNELS)) u_front (
    .push     (push),
    .item     (item),
    .cfg      (cfg),
    .q_full   (full),
    .cmd_push (cmd_push),
    .cmd      (front_cmd)
  );

  // Command queue between front and back
  pmt_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (front_cmd),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (back_cmd),
    .empty (cmd_empty)
  );

  // Execute commands
  pmt_back #(.CHANNELS(CHANNELS), .COUNTER_BITS(COUNTER_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (back_cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .out_full  (out_full),
    .res_push  (res_push),
    .result    (back_result)
  );

  // Result queue
  pmt_fifo #(.WIDTH($bits(result_t)), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_result),
    .full  (out_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

/* src/pmt_fifo.sv */
// Small register-based queue used between front and back and on the result side.
// No package dependency; WIDTH and DEPTH (power of two) set by the parent.
module pmt_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (AW+1)'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_push && !do_pop)      count <= count + (AW+1)'(1);
      else if (do_pop && !do_push) count <= count - (AW+1)'(1);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

/* src/pmt_front.sv */
// Front end: takes input transactions, classifies them and clamps set levels.
// Depends on pmt_pkg; feeds the command queue.
module pmt_front #(
  parameter int CHANNELS = pmt_pkg::CHANNELS_DEF
) (
  input  logic            push,
  input  pmt_pkg::item_t  item,
  input  pmt_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            cmd_push,
  output pmt_pkg::cmd_t   cmd
);
  import pmt_pkg::*;

  assign cmd_push = push && !q_full;

  // Decode opcode; out-of-range set-level channels become no-ops
  always_comb begin
    cmd.channel = item.channel;
    cmd.level   = (item.level > cfg.period) ? cfg.period : item.level;
    case (item.op)
      OP_TICK:    cmd.kind = CMD_TICK;
      OP_SET:     cmd.kind = (int'(item.channel) < CHANNELS) ? CMD_SET : CMD_NOP;
      OP_ALL_OFF: cmd.kind = CMD_ALL_OFF;
      OP_ALL_ON:  cmd.kind = CMD_ALL_ON;
      default:    cmd.kind = CMD_NOP;
    endcase
  end

endmodule

/* src/pmt_back.sv */
// Back end: prescaler, main counter, three-stage compare buffering and pin logic.
// Depends on pmt_pkg; drains the command queue into the result queue.
module pmt_back #(
  parameter int CHANNELS     = pmt_pkg::CHANNELS_DEF,
  parameter int COUNTER_BITS = pmt_pkg::COUNTER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pmt_pkg::cfg_t     cfg,
  input  pmt_pkg::cmd_t     cmd,
  input  logic              cmd_empty,
  output logic              cmd_pop,
  input  logic              out_full,
  output logic              res_push,
  output pmt_pkg::result_t  result
);
  import pmt_pkg::*;

  localparam int CMP_W = (COUNTER_BITS > LEVEL_W) ? COUNTER_BITS : LEVEL_W;

  logic [PSC_W-1:0]                   prescale_count;
  logic [PSC_W-1:0]                   prescale_count_next;
  logic [COUNTER_BITS-1:0]            main_count;
  logic [COUNTER_BITS-1:0]            main_count_next;
  logic [CHANNELS-1:0][LEVEL_W-1:0]   pending_level;
  logic [CHANNELS-1:0][LEVEL_W-1:0]   pending_level_next;
  logic [CHANNELS-1:0][LEVEL_W-1:0]   preload_level;
  logic [CHANNELS-1:0][LEVEL_W-1:0]   preload_level_next;
  logic [CHANNELS-1:0][LEVEL_W-1:0]   active_level;
  logic [CHANNELS-1:0][LEVEL_W-1:0]   active_level_next;
  logic                               upd;
  logic                               fire;
  logic [LEVEL_W:0]                   limit;
  logic [CMP_W-1:0]                   cnt_ext;

  assign fire     = !cmd_empty && !out_full;
  assign cmd_pop  = fire;
  assign res_push = fire;
  assign limit    = ((LEVEL_W+1)'(1) << cfg.prescale_shift) - (LEVEL_W+1)'(1);

  // Next-state logic for one command
  always_comb begin
    prescale_count_next = prescale_count;
    main_count_next     = main_count;
    pending_level_next  = pending_level;
    preload_level_next  = preload_level;
    active_level_next   = active_level;
    upd                 = 1'b0;
    case (cmd.kind)
      CMD_TICK: begin
        if (cfg.counter_enable) begin
          if ((LEVEL_W+1)'(prescale_count) >= limit) begin
            prescale_count_next = '0;
            if (CMP_W'(main_count) >= CMP_W'(cfg.period)) begin
              main_count_next    = '0;
              upd                = 1'b1;
              active_level_next  = preload_level;
              preload_level_next = pending_level;
            end else begin
              main_count_next = main_count + COUNTER_BITS'(1);
            end
          end else begin
            prescale_count_next = prescale_count + PSC_W'(1);
          end
        end
      end
      CMD_SET: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (int'(cmd.channel) == i) pending_level_next[i] = cmd.level;
        end
      end
      CMD_ALL_OFF: pending_level_next = '0;
      CMD_ALL_ON: begin
        for (int i = 0; i < CHANNELS; i++) pending_level_next[i] = cfg.period;
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      main_count     <= '0;
      pending_level  <= '0;
      preload_level  <= '0;
      active_level   <= '0;
    end else if (fire) begin
      prescale_count <= prescale_count_next;
      main_count     <= main_count_next;
      pending_level  <= pending_level_next;
      preload_level  <= preload_level_next;
      active_level   <= active_level_next;
    end
  end

  // Result fields from the state after this command
  assign cnt_ext               = CMP_W'(main_count_next);
  assign result.counter_value  = cnt_ext[LEVEL_W-1:0];
  assign result.update_event   = upd;

  for (genvar b = 0; b < PIN_W; b++) begin : g_pin
    if (b < CHANNELS) begin : g_used
      assign result.pwm_out[b] =
        ((cnt_ext < CMP_W'(active_level_next[b])) ^ cfg.output_polarity) &
        cfg.output_enable_mask[b];
    end else begin : g_unused
      assign result.pwm_out[b] = 1'b0;
    end
  end

  // Checks
  a_wrap_zero: assert property (@(posedge clk) disable iff (rst)
    fire && upd |-> main_count_next == '0)
    else $error("update without counter wrap to zero");

  a_hold_non_tick: assert property (@(posedge clk) disable iff (rst)
    fire && cmd.kind != CMD_TICK |=> $stable(main_count) && $stable(prescale_count))
    else $error("counter moved on a non-tick command");

  a_active_on_update: assert property (@(posedge clk) disable iff (rst)
    !(fire && upd) |=> $stable(active_level) && $stable(preload_level))
    else $error("compare buffers changed without update event");

  a_no_update_non_tick: assert property (@(posedge clk) disable iff (rst)
    fire && cmd.kind != CMD_TICK |-> !upd)
    else $error("update event on a non-tick command");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for multi_channel_pwm_timer: a directed table, then random phases.
// Depends on pmt_pkg and the multi_channel_pwm_timer RTL; predicts untyped results in-line.
module tb_top;
  import pmt_pkg::*;

  localparam int NCH         = CHANNELS_DEF;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 86;
  localparam int STALL_LIMIT = 1000;

  // One row of the directed table: a register write or an input transaction
  typedef struct {
    bit          is_cfg;
    logic [2:0]  reg_idx;
    logic [15:0] data;
    item_t       it;
    bit          fixed;
    result_t     want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  item_t       item = '0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  result_t     result;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Typed-in expectation that travels with the item being offered
  logic        item_fixed = 1'b0;
  result_t     item_want = '0;

  // Timer model state and its copy of the registers
  logic [PSC_W-1:0]   psc_cnt;
  logic [15:0]        main_cnt;
  logic [15:0]        pend_lvl [NCH];
  logic [15:0]        pre_lvl [NCH];
  logic [15:0]        act_lvl [NCH];
  logic [3:0]         shift_r;
  logic [15:0]        period_r;
  logic               enable_r;
  logic               polarity_r;
  logic [PIN_W-1:0]   mask_r;

  result_t   pwm_expected_q [$];
  plan_row_t plan [$];
  int        errors = 0;
  int        stall_cycles = 0;
  int        tx_idle_pct = 11;
  int        rx_idle_pct = 71;

  always #5 clk = ~clk;

  multi_channel_pwm_timer dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------- timer model

  function automatic void timer_reset();
    psc_cnt    = '0;
    main_cnt   = '0;
    shift_r    = RST_SHIFT;
    period_r   = RST_PERIOD;
    enable_r   = RST_ENABLE;
    polarity_r = RST_POLARITY;
    mask_r     = RST_OUTMASK;
    for (int i = 0; i < NCH; i++) begin
      pend_lvl[i] = '0;
      pre_lvl[i]  = '0;
      act_lvl[i]  = '0;
    end
  endfunction

  function automatic void timer_config(logic [2:0] idx, logic [15:0] data);
    case (idx)
      REG_PRESCALE_SHIFT: shift_r = data[3:0];
      REG_PERIOD:         period_r = data;
      REG_COUNTER_ENABLE: enable_r = data[0];
      REG_POLARITY:       polarity_r = data[0];
      REG_OUTPUT_MASK:    mask_r = data[PIN_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the timer by one transaction and return the pins and counter it shows
  function automatic result_t timer_step(item_t it);
    result_t     r;
    logic [15:0] lvl;
    int unsigned lim;
    logic        on;
    r = '0;
    case (it.op)
      OP_TICK: begin
        if (enable_r) begin
          lim = (32'd1 << shift_r) - 1;
          if (psc_cnt >= lim) begin
            psc_cnt = '0;
            // wrap also catches a counter left above a lowered period
            if (main_cnt >= period_r) begin
              main_cnt = '0;
              r.update_event = 1'b1;
              for (int i = 0; i < NCH; i++) begin
                act_lvl[i] = pre_lvl[i];
                pre_lvl[i] = pend_lvl[i];
              end
            end else begin
              main_cnt = main_cnt + 16'd1;
            end
          end else begin
            psc_cnt = psc_cnt + 1'b1;
          end
        end
      end
      OP_SET: begin
        lvl = (it.level > period_r) ? period_r : it.level;
        if (it.channel < NCH) pend_lvl[it.channel] = lvl;
      end
      OP_ALL_OFF: begin
        for (int i = 0; i < NCH; i++) pend_lvl[i] = '0;
      end
      default: begin
        for (int i = 0; i < NCH; i++) pend_lvl[i] = period_r;
      end
    endcase
    for (int i = 0; i < NCH; i++) begin
      on = (main_cnt < act_lvl[i]) ^ polarity_r;
      r.pwm_out[i] = on & mask_r[i];
    end
    r.counter_value = main_cnt;
    return r;
  endfunction

  // ---------------------------------------------------------------- monitor

  task automatic report_mismatch(string name, logic [15:0] want, logic [15:0] got);
    $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    errors++;
  endtask

  // Track accepted transactions, predict, compare, and watch for a hang
  always @(posedge clk) begin : monitor
    result_t want;
    bit      moved;
    moved = 1'b0;
    if (rst) begin
      timer_reset();
      stall_cycles = 0;
    end else begin
      if (cfg_wr_en) begin
        timer_config(cfg_index, cfg_data);
        moved = 1'b1;
      end
      if (push && !full) begin
        want = timer_step(item);
        if (item_fixed) want = item_want;
        pwm_expected_q.push_back(want);
        moved = 1'b1;
      end
      if (pop && !empty) begin
        moved = 1'b1;
        if (pwm_expected_q.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, got %h", $time, result);
          errors++;
        end else begin
          want = pwm_expected_q.pop_front();
          if (result.pwm_out !== want.pwm_out)
            report_mismatch("pwm_out", 16'(want.pwm_out), 16'(result.pwm_out));
          if (result.update_event !== want.update_event)
            report_mismatch("update_event", 16'(want.update_event), 16'(result.update_event));
          if (result.counter_value !== want.counter_value)
            report_mismatch("counter_value", want.counter_value, result.counter_value);
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Result side: random back-pressure
  always @(posedge clk) pop <= ($urandom_range(0, 99) >= rx_idle_pct);

  // ---------------------------------------------------------------- drivers

  task automatic send_item(item_t it, bit fixed, result_t want);
    cfg_wr_en <= 1'b0;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push       <= 1'b1;
    item       <= it;
    item_fixed <= fixed;
    item_want  <= want;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Leaves the write enable high; the next item lowers it
  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Wait until every expected result is back, then idle with push low
  task automatic drain();
    push <= 1'b0;
    @(posedge clk);
    while (pwm_expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic plan_row_t cfg_row(logic [2:0] idx, logic [15:0] data);
    plan_row_t row;
    row = '{is_cfg: 1'b1, reg_idx: idx, data: data, it: '0, fixed: 1'b0, want: '0};
    return row;
  endfunction

  function automatic plan_row_t item_row(logic [1:0] op, logic [1:0] ch, logic [15:0] lvl,
                                         bit fixed, result_t want);
    plan_row_t row;
    row = '{is_cfg: 1'b0, reg_idx: '0, data: '0, it: '{op: op, channel: ch, level: lvl},
            fixed: fixed, want: want};
    return row;
  endfunction

  function automatic item_t rand_item(logic [15:0] per);
    item_t it;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 70)      it.op = OP_TICK;
    else if (r < 88) it.op = OP_SET;
    else if (r < 94) it.op = OP_ALL_OFF;
    else             it.op = OP_ALL_ON;
    it.channel = 2'($urandom_range(0, 3));
    // levels mostly around the period so compares actually toggle
    r = $urandom_range(0, 99);
    if (r < 45)      it.level = 16'($urandom_range(0, per + 1));
    else if (r < 75) it.level = 16'($urandom_range(0, 65535));
    else if (r < 88) it.level = 16'd0;
    else             it.level = 16'hFFFF;
    return it;
  endfunction

  // ---------------------------------------------------------------- sequence

  initial begin
    bit          last_cfg;
    logic [3:0]  shift;
    logic [15:0] per;
    logic        en;
    logic        pol;
    logic [2:0]  msk;

    // Reset defaults: levels start at zero so every output is off
    plan.push_back(item_row(OP_TICK,    2'd0, 16'd0,    1'b1, '0));
    plan.push_back(item_row(OP_SET,     2'd0, 16'hFFFF, 1'b1, '0));
    plan.push_back(item_row(OP_SET,     2'd3, 16'h1234, 1'b1, '0));
    plan.push_back(item_row(OP_ALL_ON,  2'd2, 16'd0,    1'b1, '0));
    plan.push_back(item_row(OP_ALL_OFF, 2'd1, 16'hFFFF, 1'b1, '0));
    // Every tick advances, short period: levels ripple through preload to active
    plan.push_back(cfg_row(REG_PRESCALE_SHIFT, 16'd0));
    plan.push_back(cfg_row(REG_PERIOD, 16'd2));
    plan.push_back(item_row(OP_SET, 2'd0, 16'd1,    1'b0, '0));
    plan.push_back(item_row(OP_SET, 2'd1, 16'hFFFF, 1'b0, '0));
    plan.push_back(item_row(OP_SET, 2'd2, 16'd0,    1'b0, '0));
    plan.push_back(item_row(OP_SET, 2'd3, 16'hFFFF, 1'b0, '0));
    for (int k = 0; k < 9; k++) plan.push_back(item_row(OP_TICK, 2'd0, 16'd0, 1'b0, '0));
    plan.push_back(item_row(OP_ALL_ON, 2'd0, 16'd0, 1'b0, '0));
    // Inverted outputs with channel 1 masked off
    plan.push_back(cfg_row(REG_POLARITY, 16'd1));
    plan.push_back(cfg_row(REG_OUTPUT_MASK, 16'd5));
    for (int k = 0; k < 5; k++) plan.push_back(item_row(OP_TICK, 2'd3, 16'hFFFF, 1'b0, '0));
    // Counter held: tick does nothing
    plan.push_back(cfg_row(REG_COUNTER_ENABLE, 16'd0));
    plan.push_back(item_row(OP_TICK, 2'd0, 16'd0, 1'b0, '0));
    // Period zero below a running counter: wrap on every advance
    plan.push_back(cfg_row(REG_COUNTER_ENABLE, 16'd1));
    plan.push_back(cfg_row(REG_PERIOD, 16'd0));
    plan.push_back(item_row(OP_TICK, 2'd0, 16'd0, 1'b0, '0));
    plan.push_back(item_row(OP_TICK, 2'd0, 16'd0, 1'b0, '0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    last_cfg = 1'b0;
    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        if (!last_cfg) drain();
        write_reg(plan[k].reg_idx, plan[k].data);
      end else begin
        send_item(plan[k].it, plan[k].fixed, plan[k].want);
      end
      last_cfg = plan[k].is_cfg;
    end
    drain();

    // Random phases, each with its own register setting
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES / 3) begin
        tx_idle_pct = 71;
        rx_idle_pct = 11;
      end else if (p == 2 * PHASES / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      shift = (p == 3) ? 4'd15 : 4'($urandom_range(0, 2));
      if (p == 3 || p == 6) per = 16'hFFFF;
      else if (p == 9)      per = 16'd0;
      else                  per = 16'($urandom_range(1, 7));
      en  = (p != 10);
      pol = 1'($urandom_range(0, 1));
      if (p == 1)      msk = 3'd0;
      else if (p == 2) msk = 3'd7;
      else             msk = 3'($urandom_range(0, 7));
      write_reg(REG_PRESCALE_SHIFT, 16'(shift));
      write_reg(REG_PERIOD, per);
      write_reg(REG_COUNTER_ENABLE, 16'(en));
      write_reg(REG_POLARITY, 16'(pol));
      write_reg(REG_OUTPUT_MASK, 16'(msk));
      repeat (PHASE_ITEMS) send_item(rand_item(per), 1'b0, '0);
      drain();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
